// ===== hw/rtl/kdrt_pkg.sv =====
// ----------------------------------------------------------------------------
// kdrt_pkg
// types and constants shared by the keyed dedup ring table cells and top level
// ----------------------------------------------------------------------------
package kdrt_pkg;

  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STAMP_W  = 13;
  localparam int OFFSET_W = 4;
  localparam int COUNT_W  = 16;

  // number of offsets the read field can address
  localparam int OFFSET_N = 1 << OFFSET_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  payload;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   insert_new;
    logic   update;
    entry_t item;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/kdrt_cell.sv =====
// ----------------------------------------------------------------------------
// kdrt_cell
// one slot of the table: holds an entry and its valid bit, compares the key
// of each beat, takes its neighbour's entry when a new key is pushed in
// ----------------------------------------------------------------------------
module kdrt_cell
  import kdrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  entry_t    prev_entry,
  input  logic      prev_valid,
  output entry_t    entry,
  output logic      valid,
  output logic      match
);

  assign match = valid && (entry.key == cmd.item.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.insert_new) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert_new) begin
      entry <= prev_entry;
    end else if (cmd.update && match) begin
      entry.payload <= cmd.item.payload;
      entry.stamp   <= cmd.item.stamp;
    end
  end

endmodule

// ===== hw/rtl/keyed_dedup_ring_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_dedup_ring_table_top
// table of DEPTH keyed entries, newest first, with duplicate keys merged
// ----------------------------------------------------------------------------
// Request beats arrive on req_valid / req_ready with fields kind, entry_key,
// entry_payload, stamp and read_offset. kind selects insert-or-update by key
// or a read of the entry at read_offset (taken modulo DEPTH) from the newest.
// Each request gives exactly one response beat on rsp_valid / rsp_ready.
// The table is a row of DEPTH cells, offset 0 first. Every cell compares
// its key with the request in the same cycle; a new key shifts the whole
// row one cell down, dropping the oldest entry when full.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while responses are taken, since the
// cell row compares and shifts at the edge that accepts each request.
// A stalled response holds in its register; req_ready is low only while a
// response is waiting and rsp_ready is low.
// Reset clears all valid bits, the entry count and the response valid flag;
// the table is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module keyed_dedup_ring_table_top
  import kdrt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                kind,
  input  logic [KEY_W-1:0]    entry_key,
  input  logic [DATA_W-1:0]   entry_payload,
  input  logic [STAMP_W-1:0]  stamp,
  input  logic [OFFSET_W-1:0] read_offset,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic                ok,
  output logic [OFFSET_W-1:0] position,
  output logic                is_new,
  output logic [KEY_W-1:0]    out_key,
  output logic [DATA_W-1:0]   out_payload,
  output logic [STAMP_W-1:0]  out_stamp,
  output logic [COUNT_W-1:0]  entry_count
);

  logic                accept;
  logic                is_insert;
  logic                any_match;
  logic [OFFSET_W-1:0] match_pos;
  cell_cmd_t           cmd;
  entry_t              cell_entry [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_match;
  entry_t              rd_entry [OFFSET_N];
  logic [OFFSET_N-1:0] rd_valid;
  entry_t              rd_sel;
  logic                rd_hit;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [DEPTH:0]      valid_inc;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_insert = accept && (kind == KIND_INSERT);
  assign any_match = |cell_match;

  assign cmd.item.key     = entry_key;
  assign cmd.item.payload = entry_payload;
  assign cmd.item.stamp   = stamp;
  assign cmd.update       = is_insert && any_match;
  assign cmd.insert_new   = is_insert && !any_match;

  // cell row, offset 0 is the newest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      kdrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .prev_entry (cmd.item),
        .prev_valid (1'b1),
        .entry      (cell_entry[i]),
        .valid      (cell_valid[i]),
        .match      (cell_match[i])
      );
    end else begin : g_rest
      kdrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .prev_entry (cell_entry[i-1]),
        .prev_valid (cell_valid[i-1]),
        .entry      (cell_entry[i]),
        .valid      (cell_valid[i]),
        .match      (cell_match[i])
      );
    end
  end

  // keys are unique among valid cells, so at most one match bit is set
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i]) begin
        match_pos = match_pos | OFFSET_W'(i);
      end
    end
  end

  // read offset folded onto the row
  for (genvar j = 0; j < OFFSET_N; j++) begin : g_rd
    localparam int SLOT = j % DEPTH;
    assign rd_entry[j] = cell_entry[SLOT];
    assign rd_valid[j] = cell_valid[SLOT];
  end

  assign rd_sel = rd_entry[read_offset];
  assign rd_hit = rd_valid[read_offset];

  assign count_next = (cmd.insert_new && (count != COUNT_MAX)) ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_count <= count_next;
      if (kind == KIND_READ) begin
        ok       <= rd_hit;
        position <= '0;
        is_new   <= 1'b0;
        if (rd_hit) begin
          out_key     <= rd_sel.key;
          out_payload <= rd_sel.payload;
          out_stamp   <= rd_sel.stamp;
        end else begin
          out_key     <= '0;
          out_payload <= '0;
          out_stamp   <= '0;
        end
      end else begin
        ok          <= 1'b1;
        position    <= any_match ? match_pos : '0;
        is_new      <= !any_match;
        out_key     <= entry_key;
        out_payload <= entry_payload;
        out_stamp   <= stamp;
      end
    end
  end

  assign valid_inc = {1'b0, cell_valid} + 1'b1;

  // valid cells always form an unbroken run from offset 0
  a_valid_prefix : assert property (@(posedge clk) disable iff (rst)
    $onehot(valid_inc))
    else $error("valid cells not contiguous from offset 0");

  a_single_match : assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("key held by more than one valid cell");

  a_new_fills_head : assert property (@(posedge clk) disable iff (rst)
    cmd.insert_new |=> cell_valid[0] && (cell_entry[0].key == $past(entry_key)))
    else $error("new key not placed at offset 0");

  a_count_monotonic : assert property (@(posedge clk) disable iff (rst)
    accept |=> count >= $past(count))
    else $error("entry count went down");

endmodule

// ===== dv/kdrt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kdrt_checker
// Watches both channels of the keyed dedup ring table. It keeps its own copy
// of the ring, the head and the entry count, and predicts each response on
// request beats. It compares response beats field by field, oldest
// prediction first, and counts failures for the testbench top.
// ----------------------------------------------------------------------------
module kdrt_checker
  import kdrt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  logic                kind,
  input  logic [KEY_W-1:0]    entry_key,
  input  logic [DATA_W-1:0]   entry_payload,
  input  logic [STAMP_W-1:0]  stamp,
  input  logic [OFFSET_W-1:0] read_offset,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  logic                ok,
  input  logic [OFFSET_W-1:0] position,
  input  logic                is_new,
  input  logic [KEY_W-1:0]    out_key,
  input  logic [DATA_W-1:0]   out_payload,
  input  logic [STAMP_W-1:0]  out_stamp,
  input  logic [COUNT_W-1:0]  entry_count,
  output int                  fail_count,
  output int                  outstanding
);

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] position;
    logic                is_new;
    entry_t              ent;
    logic [COUNT_W-1:0]  count;
  } table_rsp_t;

  entry_t              ring_mem [DEPTH];
  logic [DEPTH-1:0]    slot_valid;
  logic [OFFSET_W-1:0] head;
  logic [COUNT_W-1:0]  added;
  table_rsp_t          expected_rsp_q [$];
  table_rsp_t          want_rsp;
  table_rsp_t          got_rsp;
  int                  rsp_beats;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    rsp_beats   = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] response beat %0d: %s got 0x%0h, want 0x%0h", $time, rsp_beats,
               what, got, want);
    end
  endtask

  // advances the ring copy by one request and gives the response it causes
  function automatic table_rsp_t predict_table(input logic op, input entry_t req,
                                               input logic [OFFSET_W-1:0] ofs);
    table_rsp_t          r;
    logic [OFFSET_W-1:0] slot;
    logic [OFFSET_W-1:0] hit_ofs;
    logic                done;
    logic                hit;
    r       = '0;
    done    = 1'b0;
    hit     = 1'b0;
    hit_ofs = '0;
    if (op == KIND_READ) begin
      slot = head + ofs;
      if (slot_valid[slot]) begin
        r.ok  = 1'b1;
        r.ent = ring_mem[slot];
      end
      r.count = added;
      return r;
    end
    // scan newest first, stopping at the first empty slot
    for (int i = 0; i < DEPTH; i++) begin
      slot = head + i[OFFSET_W-1:0];
      if (!done) begin
        if (!slot_valid[slot]) begin
          done = 1'b1;
        end else if (ring_mem[slot].key == req.key) begin
          done    = 1'b1;
          hit     = 1'b1;
          hit_ofs = i[OFFSET_W-1:0];
        end
      end
    end
    if (hit) begin
      slot                   = head + hit_ofs;
      ring_mem[slot].payload = req.payload;
      ring_mem[slot].stamp   = req.stamp;
      r.position             = hit_ofs;
    end else begin
      head             = head - 1'b1;
      ring_mem[head]   = req;
      slot_valid[head] = 1'b1;
      if (added != COUNT_MAX) added++;
      r.is_new = 1'b1;
    end
    r.ok    = 1'b1;
    r.ent   = req;
    r.count = added;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slot_valid = '0;
      head       = '0;
      added      = '0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        got_rsp = {ok, position, is_new, out_key, out_payload, out_stamp, entry_count};
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("beat with nothing expected, key", out_key, '0);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (got_rsp.ok !== want_rsp.ok)
            report_mismatch("ok", 32'(got_rsp.ok), 32'(want_rsp.ok));
          if (got_rsp.position !== want_rsp.position)
            report_mismatch("position", 32'(got_rsp.position), 32'(want_rsp.position));
          if (got_rsp.is_new !== want_rsp.is_new)
            report_mismatch("is_new", 32'(got_rsp.is_new), 32'(want_rsp.is_new));
          if (got_rsp.ent.key !== want_rsp.ent.key)
            report_mismatch("out_key", got_rsp.ent.key, want_rsp.ent.key);
          if (got_rsp.ent.payload !== want_rsp.ent.payload)
            report_mismatch("out_payload", got_rsp.ent.payload, want_rsp.ent.payload);
          if (got_rsp.ent.stamp !== want_rsp.ent.stamp)
            report_mismatch("out_stamp", 32'(got_rsp.ent.stamp), 32'(want_rsp.ent.stamp));
          if (got_rsp.count !== want_rsp.count)
            report_mismatch("entry_count", 32'(got_rsp.count), 32'(want_rsp.count));
        end
        rsp_beats++;
      end
      if (req_valid && req_ready) begin
        expected_rsp_q.push_back(predict_table(kind, {entry_key, entry_payload, stamp},
                                               read_offset));
      end
    end
    outstanding <= expected_rsp_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyed dedup ring table. A directed opening
// covers empty reads, extreme fields, duplicates, a full table and eviction.
// Random phases follow with recent keys reused, under varied sender gaps and
// receiver stalls. Checking is done by kdrt_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import kdrt_pkg::*;

  localparam int                 DEPTH       = 16;
  localparam int                 WATCH_LIMIT = 5000;
  localparam logic [STAMP_W-1:0] STAMP_TOP   = 13'd5947;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                req_valid     = 1'b0;
  logic                req_ready;
  logic                kind          = KIND_INSERT;
  logic [KEY_W-1:0]    entry_key     = '0;
  logic [DATA_W-1:0]   entry_payload = '0;
  logic [STAMP_W-1:0]  stamp         = '0;
  logic [OFFSET_W-1:0] read_offset   = '0;
  logic                rsp_valid;
  logic                rsp_ready     = 1'b0;
  logic                ok;
  logic [OFFSET_W-1:0] position;
  logic                is_new;
  logic [KEY_W-1:0]    out_key;
  logic [DATA_W-1:0]   out_payload;
  logic [STAMP_W-1:0]  out_stamp;
  logic [COUNT_W-1:0]  entry_count;

  int                  fail_count;
  int                  outstanding;
  int                  burst_left = 0;
  bit                  gaps_on    = 1'b0;
  stall_mode_t         stall_mode = STALL_NONE;
  int                  stall_phase = 0;
  int                  quiet_cycles = 0;
  logic [KEY_W-1:0]    recent_keys [$];

  keyed_dedup_ring_table_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .entry_key    (entry_key),
    .entry_payload(entry_payload),
    .stamp        (stamp),
    .read_offset  (read_offset),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .ok           (ok),
    .position     (position),
    .is_new       (is_new),
    .out_key      (out_key),
    .out_payload  (out_payload),
    .out_stamp    (out_stamp),
    .entry_count  (entry_count)
  );

  kdrt_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .entry_key    (entry_key),
    .entry_payload(entry_payload),
    .stamp        (stamp),
    .read_offset  (read_offset),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .ok           (ok),
    .position     (position),
    .is_new       (is_new),
    .out_key      (out_key),
    .out_payload  (out_payload),
    .out_stamp    (out_stamp),
    .entry_count  (entry_count),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      STALL_NONE:    rsp_ready <= 1'b1;
      STALL_RANDOM:  rsp_ready <= ($urandom_range(0, 99) >= 30);
      default:       rsp_ready <= ((stall_phase % 7) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request beat, preceded by a gap when a burst runs out and gaps are on
  task automatic send_req(input logic op, input logic [KEY_W-1:0] k,
                          input logic [DATA_W-1:0] d, input logic [STAMP_W-1:0] s,
                          input logic [OFFSET_W-1:0] o);
    bit took;
    if (burst_left == 0) begin
      if (gaps_on) begin
        repeat ($urandom_range(1, 6)) begin
          req_valid <= 1'b0;
          @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_valid     <= 1'b1;
    kind          <= op;
    entry_key     <= k;
    entry_payload <= d;
    stamp         <= s;
    read_offset   <= o;
    if (op == KIND_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
    do begin
      @(negedge clk);
      took = req_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic wait_table_drained;
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int               pick;
    logic [KEY_W-1:0] k;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_req(KIND_READ, $urandom, $urandom, STAMP_W'($urandom_range(0, STAMP_TOP)),
                 OFFSET_W'($urandom_range(0, OFFSET_N - 1)));
      end else begin
        if (pick < 65 && recent_keys.size() != 0)
          k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (pick < 70)
          k = pick[0] ? '1 : '0;
        else
          k = $urandom;
        send_req(KIND_INSERT, k, $urandom, STAMP_W'($urandom_range(0, STAMP_TOP)),
                 OFFSET_W'($urandom_range(0, OFFSET_N - 1)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table, extreme fields, duplicate, fill, evict, oldest slot hit
    send_req(KIND_READ, '0, '0, '0, '0);
    send_req(KIND_READ, '1, '1, STAMP_TOP, '1);
    send_req(KIND_INSERT, '0, '0, '0, '0);
    send_req(KIND_INSERT, '1, '1, STAMP_TOP, '1);
    send_req(KIND_INSERT, '0, '1, STAMP_TOP, '0);
    send_req(KIND_READ, '0, '0, '0, 4'd0);
    send_req(KIND_READ, '0, '0, '0, 4'd1);
    send_req(KIND_READ, '0, '0, '0, 4'd2);
    for (int i = 1; i <= 14; i++)
      send_req(KIND_INSERT, 32'h1000_0000 + i, $urandom,
               STAMP_W'($urandom_range(0, STAMP_TOP)), '0);
    send_req(KIND_INSERT, 32'h1000_000f, $urandom, 13'h1555, '0);
    send_req(KIND_INSERT, '1, 32'h5a5a_a5a5, 13'h0aaa, '1);
    send_req(KIND_READ, '0, '0, '0, 4'd15);
    wait_table_drained();

    gaps_on = 1'b1;
    stall_mode = STALL_RANDOM;
    run_random(400);
    wait_table_drained();
    gaps_on = 1'b0;
    stall_mode = STALL_NONE;
    run_random(400);
    gaps_on = 1'b1;
    stall_mode = STALL_PATTERN;
    run_random(400);
    wait_table_drained();
    gaps_on = 1'b0;
    stall_mode = STALL_RANDOM;
    run_random(400);
    wait_table_drained();

    gaps_on = 1'b1;
    stall_mode = STALL_RANDOM;
    run_random(50);

    wait_table_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
